>>> rtl/ndvim_pkg.sv
// ----------------------------------------------------------------------------
// ndvim_pkg
// Shared types and constants for the NDVI vegetation pixel mask unit.
// ----------------------------------------------------------------------------
package ndvim_pkg;

  // Fixed field widths
  localparam int BAND_W      = 16;
  localparam int THRESH_W    = 15;
  localparam int NODATA_W    = 16;
  localparam int VALUE_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NDVI_THRESHOLD       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLUE_GREEN_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODATA_BLUE          = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODATA_GREEN         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODATA_RED           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NODATA_NIR           = 3'd5;

  // Saturation limits of the signed result
  localparam logic [VALUE_W:0] VALUE_POS_MAX = 17'd32767;
  localparam logic [VALUE_W:0] VALUE_NEG_MAG = 17'd32768;

  typedef enum logic [1:0] {
    REASON_KEPT       = 2'd0,
    REASON_NODATA     = 2'd1,
    REASON_NDVI       = 2'd2,
    REASON_BLUE_GREEN = 2'd3
  } reason_t;

  typedef struct packed {
    logic [BAND_W-1:0] blue_sample;
    logic [BAND_W-1:0] green_sample;
    logic [BAND_W-1:0] red_sample;
    logic [BAND_W-1:0] nir_sample;
  } pixel_t;

  typedef struct packed {
    logic                      pixel_kept;
    logic signed [VALUE_W-1:0] ndvi_value;
    reason_t                   reject_reason;
  } result_t;

  // Sideband that rides along the divider pipeline
  typedef struct packed {
    logic    valid;
    logic    neg;
    reason_t reason;
  } div_ctrl_t;

endpackage

>>> rtl/ndvim_ratio_divider.sv
// ----------------------------------------------------------------------------
// ndvim_ratio_divider
// Pipelined restoring divider for a proper fraction dividend < divisor.
// One quotient bit per stage, QUO_W stages, sideband carried alongside.
// ----------------------------------------------------------------------------
module ndvim_ratio_divider #(
  parameter int SUM_W = 17,
  parameter int QUO_W = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ndvim_pkg::div_ctrl_t  ctrl_in,
  input  logic [SUM_W-1:0]      dividend,
  input  logic [SUM_W-1:0]      divisor,
  output ndvim_pkg::div_ctrl_t  ctrl_out,
  output logic [QUO_W-1:0]      quotient
);
  import ndvim_pkg::*;

  div_ctrl_t        ctrl_q [QUO_W];
  logic [SUM_W-1:0] rem_q  [QUO_W];
  logic [SUM_W-1:0] div_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    div_ctrl_t        ctrl_prev;
    logic [SUM_W-1:0] rem_prev;
    logic [SUM_W-1:0] div_prev;
    logic [QUO_W-1:0] quo_prev;
    logic [SUM_W:0]   shifted;
    logic             ge;
    logic [SUM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;

    // Pick the previous stage, or the pipe input for the first one
    if (k == 0) begin : g_first
      assign ctrl_prev = ctrl_in;
      assign rem_prev  = dividend;
      assign div_prev  = divisor;
      assign quo_prev  = '0;
    end else begin : g_next
      assign ctrl_prev = ctrl_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign div_prev  = div_q[k-1];
      assign quo_prev  = quo_q[k-1];
    end

    // One restoring step: shift in a zero, subtract when it fits
    assign shifted  = {rem_prev, 1'b0};
    assign ge       = (shifted >= {1'b0, div_prev});
    assign rem_next = ge ? SUM_W'(shifted - {1'b0, div_prev}) : shifted[SUM_W-1:0];
    assign quo_next = {quo_prev[QUO_W-2:0], ge};

    // Advance sideband
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[k] <= '0;
      end else if (en) begin
        ctrl_q[k] <= ctrl_prev;
      end
    end

    // Advance partial remainder and quotient
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_next;
        div_q[k] <= div_prev;
        quo_q[k] <= quo_next;
      end
    end
  end

  assign ctrl_out = ctrl_q[QUO_W-1];
  assign quotient = quo_q[QUO_W-1];

endmodule

>>> rtl/ndvi_vegetation_pixel_mask_unit.sv
// ----------------------------------------------------------------------------
// ndvi_vegetation_pixel_mask_unit
// Flags nodata pixels, tests |NDVI| and the optional blue-green index
// against their thresholds, and reports NDVI of kept pixels in fixed point.
// ----------------------------------------------------------------------------
//  channel  | signals                             | direction
//  ---------+-------------------------------------+----------
//  pixel    | pixel_valid, pixel_ready, pixel     | in
//  result   | result_valid, result_ready, result  | out
//  cfg      | cfg_valid, cfg_ready, cfg_index,    | in
//           | cfg_data                            |
//
// One pixel request per cycle while the pipe is not stalled. Each pixel
// passes stage 1, stage 2, the divider stages and the output register.
// All stages advance together; a stalled result holds the whole pipe, and
// pixel_ready follows result_ready whenever the output register is full.
// Reset clears the valid bits and all configuration registers to zero.
// cfg_ready is always high; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ndvi_vegetation_pixel_mask_unit #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  ndvim_pkg::pixel_t                  pixel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output ndvim_pkg::result_t                 result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ndvim_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ndvim_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ndvim_pkg::*;

  localparam int SW     = (SAMPLE_BITS < BAND_W) ? SAMPLE_BITS : BAND_W;
  localparam int SUM_W  = SW + 1;
  localparam int PROD_W = THRESH_W + SUM_W;
  localparam int CMP_W  = SW + ((FRACTION_BITS > BAND_W) ? FRACTION_BITS : BAND_W);
  localparam int QX_W   = (FRACTION_BITS > VALUE_W) ? FRACTION_BITS : VALUE_W + 1;

  // Configuration registers
  logic [THRESH_W-1:0] ndvi_threshold;
  logic [THRESH_W-1:0] blue_green_threshold;
  logic [NODATA_W-1:0] nodata_blue;
  logic [NODATA_W-1:0] nodata_green;
  logic [NODATA_W-1:0] nodata_red;
  logic [NODATA_W-1:0] nodata_nir;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ndvi_threshold       <= '0;
      blue_green_threshold <= '0;
      nodata_blue          <= '0;
      nodata_green         <= '0;
      nodata_red           <= '0;
      nodata_nir           <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NDVI_THRESHOLD:       ndvi_threshold       <= cfg_data[THRESH_W-1:0];
        CFG_BLUE_GREEN_THRESHOLD: blue_green_threshold <= cfg_data[THRESH_W-1:0];
        CFG_NODATA_BLUE:          nodata_blue          <= cfg_data[NODATA_W-1:0];
        CFG_NODATA_GREEN:         nodata_green         <= cfg_data[NODATA_W-1:0];
        CFG_NODATA_RED:           nodata_red           <= cfg_data[NODATA_W-1:0];
        CFG_NODATA_NIR:           nodata_nir           <= cfg_data[NODATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipe moves when the output register can take a word
  logic en;
  assign en          = !result_valid || result_ready;
  assign pixel_ready = en;

  // Stage 1: nodata check, band differences and sums
  logic [SW-1:0]    b, g, r, n;
  logic             invalid;
  logic             nr_neg;
  logic [SW-1:0]    nr_diff, bg_diff;
  logic [SUM_W-1:0] nr_sum, bg_sum;

  assign b = pixel.blue_sample[SW-1:0];
  assign g = pixel.green_sample[SW-1:0];
  assign r = pixel.red_sample[SW-1:0];
  assign n = pixel.nir_sample[SW-1:0];

  assign invalid = (b == '0) || (b == nodata_blue[SW-1:0])  ||
                   (g == '0) || (g == nodata_green[SW-1:0]) ||
                   (r == '0) || (r == nodata_red[SW-1:0])   ||
                   (n == '0) || (n == nodata_nir[SW-1:0]);
  assign nr_neg  = (n < r);
  assign nr_diff = nr_neg ? (r - n) : (n - r);
  assign bg_diff = (b < g) ? (g - b) : (b - g);
  assign nr_sum  = {1'b0, n} + {1'b0, r};
  assign bg_sum  = {1'b0, b} + {1'b0, g};

  logic             s1_valid;
  logic             s1_invalid, s1_neg;
  logic [SW-1:0]    s1_nr_diff, s1_bg_diff;
  logic [SUM_W-1:0] s1_nr_sum, s1_bg_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_invalid <= invalid;
      s1_neg     <= nr_neg;
      s1_nr_diff <= nr_diff;
      s1_bg_diff <= bg_diff;
      s1_nr_sum  <= nr_sum;
      s1_bg_sum  <= bg_sum;
    end
  end

  // Stage 2: threshold times band sum for both indexes
  logic              s2_valid;
  logic              s2_invalid, s2_neg;
  logic [SW-1:0]     s2_nr_diff, s2_bg_diff;
  logic [SUM_W-1:0]  s2_nr_sum;
  logic [PROD_W-1:0] s2_nr_prod, s2_bg_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_invalid <= s1_invalid;
      s2_neg     <= s1_neg;
      s2_nr_diff <= s1_nr_diff;
      s2_bg_diff <= s1_bg_diff;
      s2_nr_sum  <= s1_nr_sum;
      s2_nr_prod <= PROD_W'(ndvi_threshold) * PROD_W'(s1_nr_sum);
      s2_bg_prod <= PROD_W'(blue_green_threshold) * PROD_W'(s1_bg_sum);
    end
  end

  // Exact ratio tests by cross multiplication, then pick the reject reason
  logic      nr_exceeds, bg_exceeds;
  div_ctrl_t div_ctrl_in;

  assign nr_exceeds = (CMP_W'(s2_nr_diff) << FRACTION_BITS) > CMP_W'(s2_nr_prod);
  assign bg_exceeds = (CMP_W'(s2_bg_diff) << FRACTION_BITS) > CMP_W'(s2_bg_prod);

  always_comb begin
    div_ctrl_in.valid = s2_valid;
    div_ctrl_in.neg   = s2_neg;
    if (s2_invalid) begin
      div_ctrl_in.reason = REASON_NODATA;
    end else if (!nr_exceeds) begin
      div_ctrl_in.reason = REASON_NDVI;
    end else if ((blue_green_threshold != '0) && !bg_exceeds) begin
      div_ctrl_in.reason = REASON_BLUE_GREEN;
    end else begin
      div_ctrl_in.reason = REASON_KEPT;
    end
  end

  // NDVI magnitude: (|NIR-R| << FRACTION_BITS) / (NIR+R)
  div_ctrl_t                div_ctrl_out;
  logic [FRACTION_BITS-1:0] quotient;

  ndvim_ratio_divider #(
    .SUM_W (SUM_W),
    .QUO_W (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_in  (div_ctrl_in),
    .dividend (SUM_W'(s2_nr_diff)),
    .divisor  (s2_nr_sum),
    .ctrl_out (div_ctrl_out),
    .quotient (quotient)
  );

  // Saturate, apply sign, zero the value of rejected pixels
  logic [QX_W-1:0]    q_ext;
  logic [VALUE_W-1:0] value;
  result_t            result_next;

  assign q_ext = QX_W'(quotient);

  always_comb begin
    if (div_ctrl_out.reason != REASON_KEPT) begin
      value = '0;
    end else if (div_ctrl_out.neg) begin
      if (q_ext > QX_W'(VALUE_NEG_MAG)) begin
        value = VALUE_W'(0) - VALUE_NEG_MAG[VALUE_W-1:0];
      end else begin
        value = VALUE_W'(0) - q_ext[VALUE_W-1:0];
      end
    end else begin
      if (q_ext > QX_W'(VALUE_POS_MAX)) begin
        value = VALUE_POS_MAX[VALUE_W-1:0];
      end else begin
        value = q_ext[VALUE_W-1:0];
      end
    end
    result_next.pixel_kept    = (div_ctrl_out.reason == REASON_KEPT);
    result_next.ndvi_value    = value;
    result_next.reject_reason = div_ctrl_out.reason;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= div_ctrl_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
